// ===== src/ihbm_pkg.sv =====
// Shared types and codes of the indexed binary max-heap.
package ihbm_pkg;

  localparam int NODE_BITS  = 10;
  localparam int PRIO_BITS  = 32;
  localparam int COUNT_BITS = 11;

  typedef enum logic [1:0] {
    OP_ADD,
    OP_REMOVE,
    OP_UPDATE,
    OP_QUERY
  } op_t;

  typedef enum logic [2:0] {
    ST_OK,
    ST_FULL,
    ST_EMPTY,
    ST_ABSENT,
    ST_PRESENT
  } status_t;

  typedef struct packed {
    op_t                  op;
    logic [NODE_BITS-1:0] node_id;
    logic [PRIO_BITS-1:0] priority_req;
  } req_t;

  typedef struct packed {
    status_t               status;
    logic [NODE_BITS-1:0]  top_node;
    logic [PRIO_BITS-1:0]  top_priority;
    logic                  found;
    logic [COUNT_BITS-1:0] count;
  } rsp_t;

endpackage

// ===== src/ihbm_ram.sv =====
// Generic single-port-write, single-port-read RAM with registered read data.
module ihbm_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== src/ihbm_core.sv =====
// Heap sequencer: slot and position memories with the sift state machine.
module ihbm_core #(
  parameter int CAPACITY      = 1024,
  parameter int NODE_COUNT    = 1024,
  parameter int PRIORITY_BITS = 32
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            req_valid,
  output logic            req_ready,
  input  ihbm_pkg::req_t  req,
  output logic            res_valid,
  input  logic            res_ready,
  output ihbm_pkg::rsp_t  res
);
  import ihbm_pkg::*;

  localparam int SLOT_W = $clog2(CAPACITY);
  localparam int CNT_W  = $clog2(CAPACITY + 1);
  localparam int NIDX_W = $clog2(NODE_COUNT);
  localparam int IW     = SLOT_W + 2;
  localparam int SD_W   = NODE_BITS + PRIORITY_BITS;

  typedef enum logic [3:0] {
    S_CLEAR, S_IDLE, S_LOOKUP, S_CHECK, S_UP, S_UP_CMP, S_RM_TOP, S_RM_LAST,
    S_DOWN, S_DN_L, S_DN_R, S_DN_CMP, S_WB, S_RESULT
  } state_t;

  state_t                   state;
  logic [CNT_W-1:0]         fill;
  logic [NIDX_W-1:0]        clr;
  op_t                      op;
  logic [NODE_BITS-1:0]     node;
  logic [SLOT_W-1:0]        pos;
  logic [SLOT_W-1:0]        pick;
  logic                     in_range;
  logic [NODE_BITS-1:0]     cur_node;
  logic [PRIORITY_BITS-1:0] cur_prio;
  logic [NODE_BITS-1:0]     child_node;
  logic [PRIORITY_BITS-1:0] child_prio;
  status_t                  status;
  logic [NODE_BITS-1:0]     top_node;
  logic [PRIO_BITS-1:0]     top_prio;
  logic                     found;

  // memory ports
  logic                 s_we;
  logic [SLOT_W-1:0]    s_waddr;
  logic [SD_W-1:0]      s_wdata;
  logic [SLOT_W-1:0]    s_raddr;
  logic [SD_W-1:0]      s_rdata;
  logic                 p_we;
  logic [NIDX_W-1:0]    p_waddr;
  logic [SLOT_W-1:0]    p_wdata;
  logic [NIDX_W-1:0]    p_raddr;
  logic [SLOT_W-1:0]    p_rdata;

  logic [NODE_BITS-1:0]     s_rnode;
  logic [PRIORITY_BITS-1:0] s_rprio;
  logic [SLOT_W-1:0]        parent;
  logic [IW-1:0]            left_w;
  logic [IW-1:0]            right_w;
  logic [IW-1:0]            fill_w;
  logic                     node_ok;
  logic                     present;
  logic                     up_move;
  logic                     dn_move;

  assign s_rnode = s_rdata[SD_W-1 -: NODE_BITS];
  assign s_rprio = s_rdata[PRIORITY_BITS-1:0];
  assign parent  = (pos - SLOT_W'(1)) >> 1;
  assign left_w  = IW'({pos, 1'b1});
  assign right_w = left_w + IW'(1);
  assign fill_w  = IW'(fill);
  assign node_ok = 17'(req.node_id) < 17'(NODE_COUNT);
  assign present = in_range && (s_rnode == node);
  assign up_move = s_rprio < cur_prio;
  assign dn_move = cur_prio < child_prio;
  assign p_raddr = NIDX_W'(req.node_id);

  assign req_ready = (state == S_IDLE);
  assign res_valid = (state == S_RESULT);
  assign res = '{status: status, top_node: top_node, top_priority: top_prio,
                 found: found, count: COUNT_BITS'(fill)};

  ihbm_ram #(.WIDTH(SD_W), .DEPTH(CAPACITY)) u_slot_ram (
    .clk(clk), .we(s_we), .waddr(s_waddr), .wdata(s_wdata),
    .raddr(s_raddr), .rdata(s_rdata)
  );

  ihbm_ram #(.WIDTH(SLOT_W), .DEPTH(NODE_COUNT)) u_pos_ram (
    .clk(clk), .we(p_we), .waddr(p_waddr), .wdata(p_wdata),
    .raddr(p_raddr), .rdata(p_rdata)
  );

  // read address for the state that follows
  always_comb begin
    unique case (state)
      S_LOOKUP: s_raddr = p_rdata;
      S_UP:     s_raddr = parent;
      S_RM_TOP: s_raddr = SLOT_W'(fill - CNT_W'(1));
      S_DOWN:   s_raddr = SLOT_W'(left_w);
      S_DN_L:   s_raddr = SLOT_W'(right_w);
      default:  s_raddr = '0;
    endcase
  end

  // hole technique: displaced entries move in, moving entry lands at the end
  always_comb begin
    s_we    = 1'b0;
    s_waddr = pos;
    s_wdata = {cur_node, cur_prio};
    p_we    = 1'b0;
    p_waddr = NIDX_W'(cur_node);
    p_wdata = pos;
    unique case (state)
      S_CLEAR: begin
        p_we    = 1'b1;
        p_waddr = clr;
        p_wdata = '0;
      end
      S_UP_CMP: begin
        s_we    = up_move;
        s_wdata = s_rdata;
        p_we    = up_move;
        p_waddr = NIDX_W'(s_rnode);
      end
      S_DN_CMP: begin
        s_we    = dn_move;
        s_wdata = {child_node, child_prio};
        p_we    = dn_move;
        p_waddr = NIDX_W'(child_node);
      end
      S_WB: begin
        s_we = 1'b1;
        p_we = 1'b1;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
      clr   <= '0;
      fill  <= '0;
    end else begin
      unique case (state)
        S_CLEAR: begin
          clr <= clr + NIDX_W'(1);
          if (clr == NIDX_W'(NODE_COUNT - 1)) state <= S_IDLE;
        end
        S_IDLE: begin
          if (req_valid) begin
            op       <= req.op;
            node     <= req.node_id;
            cur_node <= req.node_id;
            cur_prio <= PRIORITY_BITS'(req.priority_req);
            top_node <= '0;
            top_prio <= '0;
            found    <= 1'b0;
            if (req.op == OP_REMOVE) begin
              status <= (fill == '0) ? ST_EMPTY : ST_OK;
              state  <= (fill == '0) ? S_RESULT : S_RM_TOP;
            end else if (!node_ok) begin
              status <= (req.op == OP_QUERY) ? ST_OK : ST_ABSENT;
              state  <= S_RESULT;
            end else begin
              status <= ST_OK;
              state  <= S_LOOKUP;
            end
          end
        end
        S_LOOKUP: begin
          pos      <= p_rdata;
          in_range <= CNT_W'(p_rdata) < fill;
          state    <= S_CHECK;
        end
        S_CHECK: begin
          unique case (op)
            OP_QUERY: begin
              found <= present;
              state <= S_RESULT;
            end
            OP_ADD: begin
              if (present) begin
                status <= ST_PRESENT;
                state  <= S_RESULT;
              end else if (fill == CNT_W'(CAPACITY)) begin
                status <= ST_FULL;
                state  <= S_RESULT;
              end else begin
                pos   <= SLOT_W'(fill);
                fill  <= fill + CNT_W'(1);
                state <= S_UP;
              end
            end
            OP_UPDATE: begin
              if (!present) begin
                status <= ST_ABSENT;
                state  <= S_RESULT;
              end else begin
                state <= S_UP;
              end
            end
            OP_REMOVE: state <= S_RESULT;
          endcase
        end
        S_UP: begin
          if (pos == '0) state <= (op == OP_UPDATE) ? S_DOWN : S_WB;
          else           state <= S_UP_CMP;
        end
        S_UP_CMP: begin
          if (up_move) begin
            pos   <= parent;
            state <= S_UP;
          end else begin
            state <= (op == OP_UPDATE) ? S_DOWN : S_WB;
          end
        end
        S_RM_TOP: begin
          top_node <= s_rnode;
          top_prio <= PRIO_BITS'(s_rprio);
          fill     <= fill - CNT_W'(1);
          state    <= S_RM_LAST;
        end
        S_RM_LAST: begin
          cur_node <= s_rnode;
          cur_prio <= s_rprio;
          pos      <= '0;
          state    <= S_DOWN;
        end
        S_DOWN: begin
          state <= (left_w >= fill_w) ? S_WB : S_DN_L;
        end
        S_DN_L: begin
          child_node <= s_rnode;
          child_prio <= s_rprio;
          pick       <= SLOT_W'(left_w);
          state      <= (right_w < fill_w) ? S_DN_R : S_DN_CMP;
        end
        S_DN_R: begin
          if (child_prio < s_rprio) begin
            child_node <= s_rnode;
            child_prio <= s_rprio;
            pick       <= SLOT_W'(right_w);
          end
          state <= S_DN_CMP;
        end
        S_DN_CMP: begin
          if (dn_move) begin
            pos   <= pick;
            state <= S_DOWN;
          end else begin
            state <= S_WB;
          end
        end
        S_WB:     state <= S_RESULT;
        S_RESULT: if (res_ready) state <= S_IDLE;
        default:  state <= S_IDLE;
      endcase
    end
  end

`ifndef ASSERT_OFF
  a_fill_bound: assert property (@(posedge clk) disable iff (rst)
    fill <= CNT_W'(CAPACITY))
    else $error("heap fill count beyond capacity");

  a_fill_step: assert property (@(posedge clk) disable iff (rst)
    !$stable(fill) |-> (fill == $past(fill) + CNT_W'(1)) ||
                       (fill == $past(fill) - CNT_W'(1)))
    else $error("heap fill count moved by more than one");

  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    req_valid && req_ready |=> state != S_IDLE)
    else $error("accepted transaction left sequencer idle");

  a_hole_write: assert property (@(posedge clk) disable iff (rst)
    s_we |-> p_we && (p_wdata == s_waddr))
    else $error("slot write without matching position write");
`endif

endmodule

// ===== src/indexed_binary_max_heap.sv =====
// Top level of the indexed binary max-heap priority queue.
//
// Indexed binary max-heap over node handles, used as the open set of a path
// search. One request transaction carries one operation (add, remove top,
// update priority, membership query) and yields exactly one response
// transaction with status, removed node/priority, found flag and the heap
// count after the operation. Heap slots live in one synchronous RAM
// (handle + priority per slot) and a second RAM maps each handle to its slot.
// Operations run one at a time on a sequencer bound by the single slot RAM
// read port: query does one position lookup and a presence check; add climbs
// one level per parent read; remove reads the top and last entries, then
// descends with a read of each child per level; update runs both sifts.
// After reset the position RAM is cleared, one entry per cycle, before the
// first request is taken. A finished response waits in an output register,
// so the next request can start while the consumer stalls.
module indexed_binary_max_heap #(
  parameter int CAPACITY      = 1024,
  parameter int NODE_COUNT    = 1024,
  parameter int PRIORITY_BITS = 32
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            req_valid,
  output logic            req_ready,
  input  ihbm_pkg::req_t  req,
  output logic            rsp_valid,
  input  logic            rsp_ready,
  output ihbm_pkg::rsp_t  rsp
);
  import ihbm_pkg::*;

  logic core_valid;
  logic core_ready;
  rsp_t core_rsp;

  // the output register takes a new response whenever it is empty or drains
  assign core_ready = !rsp_valid || rsp_ready;

  ihbm_core #(
    .CAPACITY(CAPACITY),
    .NODE_COUNT(NODE_COUNT),
    .PRIORITY_BITS(PRIORITY_BITS)
  ) u_core (
    .clk(clk),
    .rst(rst),
    .req_valid(req_valid),
    .req_ready(req_ready),
    .req(req),
    .res_valid(core_valid),
    .res_ready(core_ready),
    .res(core_rsp)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (core_valid && core_ready) begin
      rsp_valid <= 1'b1;
      rsp       <= core_rsp;
    end else if (rsp_ready) begin
      rsp_valid <= 1'b0;
    end
  end

endmodule

// ===== verif/tb_indexed_binary_max_heap.sv =====
// Testbench for the indexed binary max-heap: directed table, then random operations.
`timescale 1ns / 100ps

module tb_indexed_binary_max_heap;
  import ihbm_pkg::*;

  localparam int HEAP_CAP   = 1024;
  localparam int HANDLES    = 1024;
  localparam int RANDOM_OPS = 550;
  localparam int CYCLE_LIMIT = 400000;

  logic clk;
  logic rst;
  logic req_valid;
  logic req_ready;
  req_t req;
  logic rsp_valid;
  logic rsp_ready;
  rsp_t rsp;

  indexed_binary_max_heap uut (
    .clk(clk),
    .rst(rst),
    .req_valid(req_valid),
    .req_ready(req_ready),
    .req(req),
    .rsp_valid(rsp_valid),
    .rsp_ready(rsp_ready),
    .rsp(rsp)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // Shadow heap state, kept in step with accepted requests.
  logic [NODE_BITS-1:0]  heap_node [HEAP_CAP];
  logic [PRIO_BITS-1:0]  heap_prio [HEAP_CAP];
  logic [NODE_BITS-1:0]  handle_slot [HANDLES];
  int unsigned           heap_fill;

  rsp_t expected_rsps [$];
  int   mismatches;
  int   cycles;

  function automatic bit handle_present(logic [NODE_BITS-1:0] h);
    int unsigned p;
    p = 32'(handle_slot[h]);
    return (p < heap_fill) && (heap_node[p] == h);
  endfunction

  function automatic void swap_heap_slots(int unsigned a, int unsigned b);
    logic [NODE_BITS-1:0] na;
    logic [NODE_BITS-1:0] nb;
    logic [PRIO_BITS-1:0] pa;
    na = heap_node[a];
    nb = heap_node[b];
    pa = heap_prio[a];
    heap_node[a] = nb;
    heap_node[b] = na;
    heap_prio[a] = heap_prio[b];
    heap_prio[b] = pa;
    handle_slot[na] = NODE_BITS'(b);
    handle_slot[nb] = NODE_BITS'(a);
  endfunction

  function automatic int unsigned bubble_up(int unsigned p);
    int unsigned par;
    while (p != 0) begin
      par = (p - 1) / 2;
      if (heap_prio[par] < heap_prio[p]) begin
        swap_heap_slots(p, par);
        p = par;
      end else begin
        break;
      end
    end
    return p;
  endfunction

  function automatic void bubble_down(int unsigned p);
    int unsigned l;
    int unsigned pick;
    forever begin
      l = 2 * p + 1;
      if (l >= heap_fill) break;
      pick = l;
      if (l + 1 < heap_fill && heap_prio[l] < heap_prio[l+1]) pick = l + 1;
      if (heap_prio[p] < heap_prio[pick]) begin
        swap_heap_slots(p, pick);
        p = pick;
      end else begin
        break;
      end
    end
  endfunction

  // Apply one operation to the shadow heap and return the response it earns.
  function automatic rsp_t heap_apply(req_t r);
    rsp_t o;
    int unsigned p;
    o = '0;
    o.status = ST_OK;
    case (r.op)
      OP_ADD: begin
        if (handle_present(r.node_id)) begin
          o.status = ST_PRESENT;
        end else if (heap_fill >= HEAP_CAP) begin
          o.status = ST_FULL;
        end else begin
          p = heap_fill;
          heap_node[p] = r.node_id;
          heap_prio[p] = r.priority_req;
          handle_slot[r.node_id] = NODE_BITS'(p);
          heap_fill++;
          void'(bubble_up(p));
        end
      end
      OP_REMOVE: begin
        if (heap_fill == 0) begin
          o.status = ST_EMPTY;
        end else begin
          o.top_node = heap_node[0];
          o.top_priority = heap_prio[0];
          heap_fill--;
          heap_node[0] = heap_node[heap_fill];
          heap_prio[0] = heap_prio[heap_fill];
          handle_slot[heap_node[0]] = '0;
          bubble_down(0);
        end
      end
      OP_UPDATE: begin
        if (!handle_present(r.node_id)) begin
          o.status = ST_ABSENT;
        end else begin
          p = 32'(handle_slot[r.node_id]);
          heap_prio[p] = r.priority_req;
          p = bubble_up(p);
          bubble_down(p);
        end
      end
      default: o.found = handle_present(r.node_id);
    endcase
    o.count = heap_fill[COUNT_BITS-1:0];
    return o;
  endfunction

  // Directed table: request, whether a literal expectation applies, and that value.
  typedef struct {
    req_t r;
    bit   fixed;
    rsp_t e;
  } dir_row_t;

  dir_row_t dir_rows [$];

  function automatic req_t mk_req(op_t o, int n, logic [31:0] p);
    req_t r;
    r.op = o;
    r.node_id = n[NODE_BITS-1:0];
    r.priority_req = p;
    return r;
  endfunction

  function automatic rsp_t mk_rsp(status_t s, int n, logic [31:0] p, bit f, int c);
    rsp_t o;
    o.status = s;
    o.top_node = n[NODE_BITS-1:0];
    o.top_priority = p;
    o.found = f;
    o.count = c[COUNT_BITS-1:0];
    return o;
  endfunction

  task automatic add_row(req_t r, bit fixed, rsp_t e);
    dir_row_t d;
    d.r = r;
    d.fixed = fixed;
    d.e = e;
    dir_rows.push_back(d);
  endtask

  // Drive one request transaction; the predictor runs when it is accepted.
  task automatic send_req(req_t r, bit fixed, rsp_t e);
    rsp_t pred;
    req <= r;
    req_valid <= 1'b1;
    @(posedge clk);
    while (!req_ready) @(posedge clk);
    pred = heap_apply(r);
    if (fixed && pred !== e) begin
      mismatches++;
      if (mismatches <= 10)
        $display("directed row disagrees with predictor: %p vs %p", e, pred);
    end
    expected_rsps.push_back(fixed ? e : pred);
    @(negedge clk);
  endtask

  // Sender gap: idle for a random number of cycles between bursts.
  task automatic idle_gap();
    int g;
    g = $urandom_range(0, 6);
    if (g != 0) begin
      req_valid <= 1'b0;
      repeat (g) @(negedge clk);
    end
  endtask

  // Response checker: compare every accepted response with the oldest expectation.
  always @(posedge clk) begin
    if (!rst && rsp_valid && rsp_ready) begin
      if (expected_rsps.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected response transaction: %p", rsp);
      end else begin
        rsp_t e;
        e = expected_rsps.pop_front();
        if (rsp.status !== e.status || rsp.top_node !== e.top_node ||
            rsp.top_priority !== e.top_priority || rsp.found !== e.found ||
            rsp.count !== e.count) begin
          mismatches++;
          if (mismatches <= 10)
            $display("response mismatch: expected %p, got %p", e, rsp);
        end
      end
    end
  end

  // Receiver stall pattern: stretches of full readiness and random back-pressure.
  int stall_mode;
  always @(negedge clk) begin
    if (rst) begin
      rsp_ready <= 1'b0;
      stall_mode <= 0;
    end else begin
      if ($urandom_range(0, 63) == 0) stall_mode <= $urandom_range(0, 2);
      case (stall_mode)
        0: rsp_ready <= 1'b1;
        1: rsp_ready <= ($urandom_range(0, 3) != 0);
        default: rsp_ready <= ($urandom_range(0, 3) == 0);
      endcase
    end
  end

  // Watchdog
  always @(posedge clk) begin
    cycles++;
    if (cycles >= CYCLE_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  initial begin
    int burst;
    int kind;
    int n;
    logic [31:0] pr;
    req_t r;
    rsp_t none;

    mismatches = 0;
    cycles = 0;
    heap_fill = 0;
    none = '0;
    for (int i = 0; i < HANDLES; i++) handle_slot[i] = '0;
    for (int i = 0; i < HEAP_CAP; i++) begin
      heap_node[i] = '0;
      heap_prio[i] = '0;
    end
    rst = 1'b1;
    req_valid = 1'b0;
    req = '0;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Directed part: empty cases, extremes, duplicate add, absent update, ties.
    add_row(mk_req(OP_REMOVE, 0, 0), 1, mk_rsp(ST_EMPTY, 0, 0, 0, 0));
    add_row(mk_req(OP_QUERY, 0, 0), 1, mk_rsp(ST_OK, 0, 0, 0, 0));
    add_row(mk_req(OP_UPDATE, 1023, 5), 1, mk_rsp(ST_ABSENT, 0, 0, 0, 0));
    add_row(mk_req(OP_ADD, 0, 32'hFFFF_FFFF), 1, mk_rsp(ST_OK, 0, 0, 0, 1));
    add_row(mk_req(OP_ADD, 0, 3), 1, mk_rsp(ST_PRESENT, 0, 0, 0, 1));
    add_row(mk_req(OP_QUERY, 0, 0), 1, mk_rsp(ST_OK, 0, 0, 1, 1));
    add_row(mk_req(OP_ADD, 1023, 0), 1, mk_rsp(ST_OK, 0, 0, 0, 2));
    add_row(mk_req(OP_ADD, 5, 100), 0, none);
    add_row(mk_req(OP_ADD, 6, 100), 0, none);
    add_row(mk_req(OP_ADD, 7, 100), 0, none);
    add_row(mk_req(OP_UPDATE, 1023, 32'hFFFF_FFFF), 0, none);
    add_row(mk_req(OP_UPDATE, 0, 1), 0, none);
    add_row(mk_req(OP_QUERY, 1023, 0), 0, none);
    add_row(mk_req(OP_QUERY, 600, 0), 0, none);
    for (int i = 0; i < 6; i++) add_row(mk_req(OP_REMOVE, 0, 0), 0, none);
    add_row(mk_req(OP_REMOVE, 0, 0), 1, mk_rsp(ST_EMPTY, 0, 0, 0, 0));
    add_row(mk_req(OP_QUERY, 5, 0), 1, mk_rsp(ST_OK, 0, 0, 0, 0));

    foreach (dir_rows[i]) begin
      send_req(dir_rows[i].r, dir_rows[i].fixed, dir_rows[i].e);
      if ($urandom_range(0, 2) == 0) idle_gap();
    end

    // Random part in bursts. Mostly well-formed traffic on a smallish handle set;
    // phase 2 fills the heap to capacity.
    burst = 0;
    for (int i = 0; i < RANDOM_OPS; i++) begin
      kind = $urandom_range(0, 99);
      n = ($urandom_range(0, 3) == 0) ? $urandom_range(0, HANDLES - 1)
                                      : $urandom_range(0, 63);
      case ($urandom_range(0, 3))
        0: pr = $urandom;
        1: pr = $urandom_range(0, 7);
        2: pr = 32'hFFFF_FFF8 | $urandom_range(0, 7);
        default: pr = $urandom_range(0, 255) << 24;
      endcase
      if (kind < 40)      r = mk_req(OP_ADD, n, pr);
      else if (kind < 65) r = mk_req(OP_REMOVE, $urandom, $urandom);
      else if (kind < 85) r = mk_req(OP_UPDATE, n, pr);
      else                r = mk_req(OP_QUERY, n, $urandom);
      send_req(r, 0, none);
      if (burst == 0) begin
        idle_gap();
        burst = $urandom_range(1, 20);
      end else begin
        burst--;
      end
    end

    // Fill to capacity, probe present, update and query cases, then drain part way.
    for (int h = 0; h < HANDLES; h++) begin
      if (!handle_present(h[NODE_BITS-1:0]))
        send_req(mk_req(OP_ADD, h, $urandom), 0, none);
    end
    send_req(mk_req(OP_ADD, 17, 9), 0, none);
    send_req(mk_req(OP_UPDATE, 17, 32'hFFFF_FFFF), 0, none);
    send_req(mk_req(OP_QUERY, 1023, 0), 0, none);
    for (int i = 0; i < 64; i++) send_req(mk_req(OP_REMOVE, 0, 0), 0, none);
    req_valid <= 1'b0;

    while (expected_rsps.size() != 0) @(posedge clk);
    repeat (100) @(posedge clk);
    if (mismatches == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

// ===== indexed_binary_max_heap.f =====
src/ihbm_pkg.sv
src/ihbm_ram.sv
src/ihbm_core.sv
src/indexed_binary_max_heap.sv
verif/tb_indexed_binary_max_heap.sv
